FILE: sv/aavr_pkg.sv
package aavr_pkg;

	localparam int VEC_W   = 32;
	localparam int ANGLE_W = 20;

	typedef struct packed {
		logic signed [VEC_W-1:0]   vec_x;
		logic signed [VEC_W-1:0]   vec_y;
		logic signed [VEC_W-1:0]   vec_z;
		logic signed [VEC_W-1:0]   axis_x;
		logic signed [VEC_W-1:0]   axis_y;
		logic signed [VEC_W-1:0]   axis_z;
		logic signed [ANGLE_W-1:0] angle;
	} item_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] rot_x;
		logic signed [VEC_W-1:0] rot_y;
		logic signed [VEC_W-1:0] rot_z;
		logic                    passed_through;
	} result_t;

	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] GAIN_Q30    = 64'd652032874;
	localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [31:0] ATAN_Q30 [0:31] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
		32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000
	};

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;
	localparam int AX_LAT     = 5 + SQRT_STEPS + DIV_STEPS;

	localparam int PROD_W = 72;
	localparam int RND_W  = 42;

	function automatic logic signed [RND_W-1:0] rnd30(input logic signed [PROD_W-1:0] p);
		logic [PROD_W-1:0] m;
		logic [PROD_W-1:0] r;
		m = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		r = (m + PROD_W'(64'd536870912)) >> 30;
		rnd30 = p[PROD_W-1] ? -$signed(r[RND_W-1:0]) : $signed(r[RND_W-1:0]);
	endfunction

endpackage

FILE: sv/aavr_unit.sv
module aavr_unit (
	input  logic             clk,
	input  logic             en,
	input  logic [2:0][31:0] axis_mag,
	output logic [2:0][30:0] unit_mag
);
	localparam int SQ = aavr_pkg::SQRT_STEPS;
	localparam int DV = aavr_pkg::DIV_STEPS;

	logic [31:0]      mx;
	logic [4:0]       sh;
	logic [2:0][31:0] am_s1;
	logic [4:0]       sh_s1;
	logic [2:0][31:0] an_s2;
	logic [2:0][31:0] an_s3;
	logic [2:0][31:0] an_s4;
	logic [2:0][63:0] sq_s3;
	logic [63:0]      sum_s4;
	logic [63:0]      rad_s  [0:SQ];
	logic [63:0]      root_s [0:SQ];
	logic [2:0][31:0] anr_s  [0:SQ];
	logic [31:0]      len;
	logic [2:0][61:0] num_sd;
	logic [31:0]      len_sd;
	logic [2:0][31:0] rem_s [0:DV];
	logic [2:0][30:0] low_s [0:DV];
	logic [2:0][30:0] quo_s [0:DV];
	logic [31:0]      div_s [0:DV];

	always_comb begin
		mx = axis_mag[0];
		if (axis_mag[1] > mx) mx = axis_mag[1];
		if (axis_mag[2] > mx) mx = axis_mag[2];
		sh = '0;
		for (int b = 0; b < 30; b++) begin
			if (mx[b]) sh = 5'(30 - b);
		end
		if (mx[31] | mx[30]) sh = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1  <= axis_mag;
			sh_s1  <= sh;
			for (int i = 0; i < 3; i++) begin
				an_s2[i] <= am_s1[i] << sh_s1;
				sq_s3[i] <= an_s2[i] * an_s2[i];
			end
			an_s3  <= an_s2;
			an_s4  <= an_s3;
			sum_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
		end
	end

	assign rad_s[0]  = sum_s4;
	assign root_s[0] = '0;
	assign anr_s[0]  = an_s4;

	for (genvar j = 0; j < SQ; j++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
		logic [63:0] trial;
		assign trial = root_s[j] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rad_s[j] >= trial) begin
					rad_s[j+1]  <= rad_s[j] - trial;
					root_s[j+1] <= (root_s[j] >> 1) + BIT;
				end else begin
					rad_s[j+1]  <= rad_s[j];
					root_s[j+1] <= root_s[j] >> 1;
				end
				anr_s[j+1] <= anr_s[j];
			end
		end
	end

	assign len = root_s[SQ][31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				num_sd[i] <= (62'(anr_s[SQ][i]) << 30) + 62'(len >> 1);
			end
			len_sd <= len;
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_load
		assign rem_s[0][l] = {1'b0, num_sd[l][61:31]};
		assign low_s[0][l] = num_sd[l][30:0];
		assign quo_s[0][l] = '0;
	end
	assign div_s[0] = len_sd;

	for (genvar k = 0; k < DV; k++) begin : g_div
		logic [2:0][32:0] tr;
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				tr[l] = {rem_s[k][l], low_s[k][l][30]};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					if (tr[l] >= {1'b0, div_s[k]}) begin
						rem_s[k+1][l] <= 32'(tr[l] - {1'b0, div_s[k]});
						quo_s[k+1][l] <= {quo_s[k][l][29:0], 1'b1};
					end else begin
						rem_s[k+1][l] <= tr[l][31:0];
						quo_s[k+1][l] <= {quo_s[k][l][29:0], 1'b0};
					end
					low_s[k+1][l] <= {low_s[k][l][29:0], 1'b0};
				end
				div_s[k+1] <= div_s[k];
			end
		end
	end

	assign unit_mag = quo_s[DV];

endmodule

FILE: sv/aavr_trig.sv
module aavr_trig #(
	parameter int FRAC_BITS       = 16,
	parameter int TRIG_ITERATIONS = 18,
	parameter int OUT_LAT         = 68
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [aavr_pkg::ANGLE_W-1:0] angle,
	output logic signed [31:0]                  cosine,
	output logic signed [31:0]                  sine
);
	localparam int AW        = aavr_pkg::ANGLE_W;
	localparam int ZW        = AW + 30 - FRAC_BITS;
	localparam int ZR        = (ZW > 34) ? ZW : 34;
	localparam int MOD_STEPS = (ZW > 32) ? ZW - 32 : 0;
	localparam int CW        = 34;
	localparam int TI        = TRIG_ITERATIONS;
	localparam int PAD       = OUT_LAT - MOD_STEPS - TI - 3;
	localparam logic [ZR-1:0] TWO_PI_Z = ZR'(aavr_pkg::TWO_PI_Q30);
	localparam logic [32:0]   TWO_PI   = 33'(aavr_pkg::TWO_PI_Q30);
	localparam logic [32:0]   PI       = 33'(aavr_pkg::PI_Q30);
	localparam logic [32:0]   HALF_PI  = 33'(aavr_pkg::HALF_PI_Q30);

	logic signed [AW:0] ang_ext;
	logic [AW:0]        ang_mag;
	logic [ZR-1:0]      z_s    [0:MOD_STEPS];
	logic               sneg_s [0:MOD_STEPS];
	logic [32:0]        zr;
	logic [32:0]        zf_s1;
	logic               snf_s1;
	logic [32:0]        zf_s2;
	logic               snf_s2;
	logic               cnf_s2;
	logic signed [CW-1:0] x_s [0:TI];
	logic signed [CW-1:0] y_s [0:TI];
	logic signed [CW-1:0] t_s [0:TI];
	logic               sc_s [0:TI];
	logic               cc_s [0:TI];
	logic signed [31:0] cd_s [0:PAD];
	logic signed [31:0] sd_s [0:PAD];

	assign ang_ext   = {angle[AW-1], angle};
	assign ang_mag   = ang_ext[AW] ? (AW+1)'(-ang_ext) : (AW+1)'(ang_ext);
	assign z_s[0]    = ZR'(ang_mag) << (30 - FRAC_BITS);
	assign sneg_s[0] = angle[AW-1];

	for (genvar k = 0; k < MOD_STEPS; k++) begin : g_mod
		localparam logic [ZR-1:0] SUB = TWO_PI_Z << (MOD_STEPS - 1 - k);
		always_ff @(posedge clk) begin
			if (en) begin
				z_s[k+1]    <= (z_s[k] >= SUB) ? z_s[k] - SUB : z_s[k];
				sneg_s[k+1] <= sneg_s[k];
			end
		end
	end

	assign zr = z_s[MOD_STEPS][32:0];

	always_ff @(posedge clk) begin
		if (en) begin
			if (zr > PI) begin
				zf_s1  <= TWO_PI - zr;
				snf_s1 <= ~sneg_s[MOD_STEPS];
			end else begin
				zf_s1  <= zr;
				snf_s1 <= sneg_s[MOD_STEPS];
			end
			if (zf_s1 > HALF_PI) begin
				zf_s2  <= PI - zf_s1;
				cnf_s2 <= 1'b1;
			end else begin
				zf_s2  <= zf_s1;
				cnf_s2 <= 1'b0;
			end
			snf_s2 <= snf_s1;
		end
	end

	assign x_s[0]  = CW'(aavr_pkg::GAIN_Q30);
	assign y_s[0]  = '0;
	assign t_s[0]  = CW'(zf_s2);
	assign sc_s[0] = snf_s2;
	assign cc_s[0] = cnf_s2;

	for (genvar i = 0; i < TI; i++) begin : g_cordic
		localparam logic signed [CW-1:0] ATAN = CW'(aavr_pkg::ATAN_Q30[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				if (!t_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					t_s[i+1] <= t_s[i] - ATAN;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					t_s[i+1] <= t_s[i] + ATAN;
				end
				sc_s[i+1] <= sc_s[i];
				cc_s[i+1] <= cc_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cd_s[0] <= cc_s[TI] ? 32'(-x_s[TI]) : 32'(x_s[TI]);
			sd_s[0] <= sc_s[TI] ? 32'(-y_s[TI]) : 32'(y_s[TI]);
		end
	end

	for (genvar p = 0; p < PAD; p++) begin : g_pad
		always_ff @(posedge clk) begin
			if (en) begin
				cd_s[p+1] <= cd_s[p];
				sd_s[p+1] <= sd_s[p];
			end
		end
	end

	assign cosine = cd_s[PAD];
	assign sine   = sd_s[PAD];

endmodule

FILE: sv/axis_angle_vector_rotate.sv
// Rotates a Q16.16 vector about an axis of any length by a Q4.16 angle using
// Rodrigues' formula, saturating each component to Q16.16. A transaction is
// taken every cycle while the pipeline is not held; each result passes through
// one input register, 68 stages for the unit axis (bit-per-stage square
// root and 31-stage divider, with the angle reduction and CORDIC padded to
// match) and nine stages for the products and the final sum. The whole
// pipeline holds while a result waits, so item_ready follows result_ready
// whenever result_valid is high. A zero axis or zero angle returns the
// vector unchanged with passed_through set.
module axis_angle_vector_rotate #(
	parameter int FRAC_BITS       = 16,
	parameter int TRIG_ITERATIONS = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  aavr_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output aavr_pkg::result_t result
);
	localparam int AX_LAT = aavr_pkg::AX_LAT;
	localparam int TOT    = 1 + AX_LAT + 9;
	localparam int PW     = aavr_pkg::PROD_W;
	localparam int DW     = 36;
	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};
	localparam logic signed [DW+1:0] MAXV = (DW+2)'(64'sd2147483647);
	localparam logic signed [DW+1:0] MINV = (DW+2)'(-64'sd2147483648);

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic [2:0]         neg;
		logic               pass;
	} side_t;

	logic               en;
	logic [TOT-1:0]     vld_s;
	aavr_pkg::item_t    item_s1;
	logic signed [31:0] ax [3];
	logic [2:0][31:0]   amag;
	logic [2:0][30:0]   unit_mag;
	logic signed [31:0] cosv;
	logic signed [31:0] sinv;
	side_t              side_s [0:AX_LAT];
	side_t              sd;

	logic signed [31:0]     u_s2 [3];
	logic signed [31:0]     v_s2 [3];
	logic signed [31:0]     c_s2;
	logic signed [31:0]     s_s2;
	logic                   pass_s2;
	logic signed [PW-1:0]   pd_s3 [3];
	logic signed [PW-1:0]   pa_s3 [3];
	logic signed [PW-1:0]   pb_s3 [3];
	logic signed [PW-1:0]   pc_s3 [3];
	logic signed [33:0]     omc_s3;
	logic signed [31:0]     s_s3;
	logic signed [31:0]     u_s3 [3];
	logic signed [31:0]     v_s3 [3];
	logic                   pass_s3;
	logic signed [DW-1:0]   rd_s4 [3];
	logic signed [DW-1:0]   ra_s4 [3];
	logic signed [DW-1:0]   rb_s4 [3];
	logic signed [DW-1:0]   rc_s4 [3];
	logic signed [33:0]     omc_s4;
	logic signed [31:0]     s_s4;
	logic signed [31:0]     u_s4 [3];
	logic signed [31:0]     v_s4 [3];
	logic                   pass_s4;
	logic signed [DW-1:0]   d_s5;
	logic signed [DW-1:0]   cr_s5 [3];
	logic signed [DW-1:0]   vc_s5 [3];
	logic signed [33:0]     omc_s5;
	logic signed [31:0]     s_s5;
	logic signed [31:0]     u_s5 [3];
	logic signed [31:0]     v_s5 [3];
	logic                   pass_s5;
	logic signed [PW-1:0]   pw_s6;
	logic signed [PW-1:0]   ps_s6 [3];
	logic signed [DW-1:0]   vc_s6 [3];
	logic signed [31:0]     u_s6 [3];
	logic signed [31:0]     v_s6 [3];
	logic                   pass_s6;
	logic signed [DW-1:0]   w_s7;
	logic signed [DW-1:0]   cs_s7 [3];
	logic signed [DW-1:0]   vc_s7 [3];
	logic signed [31:0]     u_s7 [3];
	logic signed [31:0]     v_s7 [3];
	logic                   pass_s7;
	logic signed [PW-1:0]   pu_s8 [3];
	logic signed [DW-1:0]   cs_s8 [3];
	logic signed [DW-1:0]   vc_s8 [3];
	logic signed [31:0]     v_s8 [3];
	logic                   pass_s8;
	logic signed [DW-1:0]   uw_s9 [3];
	logic signed [DW-1:0]   cs_s9 [3];
	logic signed [DW-1:0]   vc_s9 [3];
	logic signed [31:0]     v_s9 [3];
	logic                   pass_s9;
	logic signed [DW+1:0]   tot [3];
	logic signed [31:0]     sat [3];
	aavr_pkg::result_t      res_s10;

	assign en           = ~vld_s[TOT-1] | result_ready;
	assign item_ready   = en;
	assign result_valid = vld_s[TOT-1];
	assign result       = res_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[TOT-2:0], item_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= item;
		end
	end

	assign ax[0] = item_s1.axis_x;
	assign ax[1] = item_s1.axis_y;
	assign ax[2] = item_s1.axis_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			amag[i] = ax[i][31] ? 32'(-ax[i]) : 32'(ax[i]);
		end
	end

	assign side_s[0].vx   = item_s1.vec_x;
	assign side_s[0].vy   = item_s1.vec_y;
	assign side_s[0].vz   = item_s1.vec_z;
	assign side_s[0].neg  = {ax[2][31], ax[1][31], ax[0][31]};
	assign side_s[0].pass = (amag == '0) || (item_s1.angle == '0);

	for (genvar k = 0; k < AX_LAT; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
			end
		end
	end

	aavr_unit u_unit (
		.clk      (clk),
		.en       (en),
		.axis_mag (amag),
		.unit_mag (unit_mag)
	);

	aavr_trig #(
		.FRAC_BITS       (FRAC_BITS),
		.TRIG_ITERATIONS (TRIG_ITERATIONS),
		.OUT_LAT         (AX_LAT)
	) u_trig (
		.clk    (clk),
		.en     (en),
		.angle  (item_s1.angle),
		.cosine (cosv),
		.sine   (sinv)
	);

	assign sd = side_s[AX_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				u_s2[i] <= sd.neg[i] ? -$signed({1'b0, unit_mag[i]})
					: $signed({1'b0, unit_mag[i]});
			end
			v_s2[0] <= sd.vx;
			v_s2[1] <= sd.vy;
			v_s2[2] <= sd.vz;
			c_s2    <= cosv;
			s_s2    <= sinv;
			pass_s2 <= sd.pass;

			for (int i = 0; i < 3; i++) begin
				pd_s3[i] <= u_s2[i] * v_s2[i];
				pa_s3[i] <= u_s2[NXT[i]] * v_s2[PRV[i]];
				pb_s3[i] <= u_s2[PRV[i]] * v_s2[NXT[i]];
				pc_s3[i] <= v_s2[i] * c_s2;
			end
			omc_s3  <= 34'sd1073741824 - 34'(c_s2);
			s_s3    <= s_s2;
			u_s3    <= u_s2;
			v_s3    <= v_s2;
			pass_s3 <= pass_s2;

			for (int i = 0; i < 3; i++) begin
				rd_s4[i] <= DW'(aavr_pkg::rnd30(pd_s3[i]));
				ra_s4[i] <= DW'(aavr_pkg::rnd30(pa_s3[i]));
				rb_s4[i] <= DW'(aavr_pkg::rnd30(pb_s3[i]));
				rc_s4[i] <= DW'(aavr_pkg::rnd30(pc_s3[i]));
			end
			omc_s4  <= omc_s3;
			s_s4    <= s_s3;
			u_s4    <= u_s3;
			v_s4    <= v_s3;
			pass_s4 <= pass_s3;

			d_s5 <= rd_s4[0] + rd_s4[1] + rd_s4[2];
			for (int i = 0; i < 3; i++) begin
				cr_s5[i] <= ra_s4[i] - rb_s4[i];
			end
			vc_s5   <= rc_s4;
			omc_s5  <= omc_s4;
			s_s5    <= s_s4;
			u_s5    <= u_s4;
			v_s5    <= v_s4;
			pass_s5 <= pass_s4;

			pw_s6 <= d_s5 * omc_s5;
			for (int i = 0; i < 3; i++) begin
				ps_s6[i] <= cr_s5[i] * s_s5;
			end
			vc_s6   <= vc_s5;
			u_s6    <= u_s5;
			v_s6    <= v_s5;
			pass_s6 <= pass_s5;

			w_s7 <= DW'(aavr_pkg::rnd30(pw_s6));
			for (int i = 0; i < 3; i++) begin
				cs_s7[i] <= DW'(aavr_pkg::rnd30(ps_s6[i]));
			end
			vc_s7   <= vc_s6;
			u_s7    <= u_s6;
			v_s7    <= v_s6;
			pass_s7 <= pass_s6;

			for (int i = 0; i < 3; i++) begin
				pu_s8[i] <= u_s7[i] * w_s7;
			end
			cs_s8   <= cs_s7;
			vc_s8   <= vc_s7;
			v_s8    <= v_s7;
			pass_s8 <= pass_s7;

			for (int i = 0; i < 3; i++) begin
				uw_s9[i] <= DW'(aavr_pkg::rnd30(pu_s8[i]));
			end
			cs_s9   <= cs_s8;
			vc_s9   <= vc_s8;
			v_s9    <= v_s8;
			pass_s9 <= pass_s8;

			res_s10.rot_x          <= pass_s9 ? v_s9[0] : sat[0];
			res_s10.rot_y          <= pass_s9 ? v_s9[1] : sat[1];
			res_s10.rot_z          <= pass_s9 ? v_s9[2] : sat[2];
			res_s10.passed_through <= pass_s9;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tot[i] = (DW+2)'(vc_s9[i]) + (DW+2)'(cs_s9[i]) + (DW+2)'(uw_s9[i]);
			if (tot[i] > MAXV) begin
				sat[i] = 32'sh7FFFFFFF;
			end else if (tot[i] < MINV) begin
				sat[i] = 32'sh80000000;
			end else begin
				sat[i] = 32'(tot[i]);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("pipeline stalled with no result waiting");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[AX_LAT] && !sd.pass |->
			unit_mag[0] <= 31'(aavr_pkg::ONE_Q30) &&
			unit_mag[1] <= 31'(aavr_pkg::ONE_Q30) &&
			unit_mag[2] <= 31'(aavr_pkg::ONE_Q30))
		else $error("unit axis component above one");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[AX_LAT] |->
			cosv <= 32'sd1073745920 && cosv >= -32'sd1073745920 &&
			sinv <= 32'sd1073745920 && sinv >= -32'sd1073745920)
		else $error("cosine or sine out of range");

endmodule
